// File: rtl/core/aupm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the alpha unpremultiply pipeline.
package aupm_pkg;

   localparam int CHAN_W = 8;
   localparam int NUM_CH = 3;
   localparam int DIV_STEPS = CHAN_W;
   localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

   localparam int CH_RED = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE = 2;

   typedef struct packed {
      logic [CHAN_W-1:0]             alpha;
      logic                          alpha_zero;
      logic [NUM_CH-1:0]             sat;
      logic [NUM_CH-1:0][CHAN_W-1:0] rem;
      logic [NUM_CH-1:0][CHAN_W-1:0] quo;
   } stage_type;

endpackage

// File: rtl/core/aupm_prep_cell.sv
`timescale 1ns / 1ps
// Entry cell: forms the rounded numerators and the zero and saturation flags.
module aupm_prep_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  logic [aupm_pkg::NUM_CH-1:0][aupm_pkg::CHAN_W-1:0] up_chan,
   input  logic [aupm_pkg::CHAN_W-1:0]     up_alpha,
   output logic                            down_valid,
   input  logic                            down_ready,
   output aupm_pkg::stage_type             down_data
);

   logic                valid_ff;
   logic                valid_in;
   aupm_pkg::stage_type data_ff;
   aupm_pkg::stage_type data_in;
   logic [2*aupm_pkg::CHAN_W-1:0] num [aupm_pkg::NUM_CH];

   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      data_in.alpha = up_alpha;
      data_in.alpha_zero = (up_alpha == '0);
      for (int i = 0; i < aupm_pkg::NUM_CH; i++) begin
         // c*255 + a/2
         num[i] = {up_chan[i], {aupm_pkg::CHAN_W{1'b0}}}
                  - {{aupm_pkg::CHAN_W{1'b0}}, up_chan[i]}
                  + {{(aupm_pkg::CHAN_W+1){1'b0}}, up_alpha[aupm_pkg::CHAN_W-1:1]};
         data_in.rem[i] = num[i][2*aupm_pkg::CHAN_W-1:aupm_pkg::CHAN_W];
         data_in.quo[i] = num[i][aupm_pkg::CHAN_W-1:0];
         data_in.sat[i] = (num[i][2*aupm_pkg::CHAN_W-1:aupm_pkg::CHAN_W] >= up_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data = data_ff;

endmodule

// File: rtl/core/aupm_div_cell.sv
`timescale 1ns / 1ps
// Division cell: one restoring quotient bit per channel.
module aupm_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  aupm_pkg::stage_type up_data,
   output logic                down_valid,
   input  logic                down_ready,
   output aupm_pkg::stage_type down_data
);

   logic                valid_ff;
   logic                valid_in;
   aupm_pkg::stage_type data_ff;
   aupm_pkg::stage_type data_in;
   logic [aupm_pkg::CHAN_W:0] shifted [aupm_pkg::NUM_CH];
   logic [aupm_pkg::CHAN_W:0] diff [aupm_pkg::NUM_CH];
   logic [aupm_pkg::NUM_CH-1:0] ge;

   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      data_in = up_data;
      for (int i = 0; i < aupm_pkg::NUM_CH; i++) begin
         shifted[i] = {up_data.rem[i], up_data.quo[i][aupm_pkg::CHAN_W-1]};
         diff[i] = shifted[i] - {1'b0, up_data.alpha};
         ge[i] = (shifted[i] >= {1'b0, up_data.alpha});
         data_in.rem[i] = ge[i] ? diff[i][aupm_pkg::CHAN_W-1:0]
                                : shifted[i][aupm_pkg::CHAN_W-1:0];
         data_in.quo[i] = {up_data.quo[i][aupm_pkg::CHAN_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data = data_ff;

endmodule

// File: rtl/core/alpha_unpremultiply_bgra_to_rgba_core.sv
`timescale 1ns / 1ps
// Alpha unpremultiply: premultiplied BGRA in, straight-alpha RGBA out.
// One pixel per clock sustained while rsp_stall is low. Each pixel is registered
// in the entry cell and then in each division cell in turn, up to rsp_valid: an entry
// cell forms c*255 + a/2, then a row of 8 division cells produces one quotient
// bit per cell for all three channels. Every cell holds its own transaction
// and only bubbles stall, so input is still taken while a finished result
// waits on rsp_stall until the whole row is full.
// Zero alpha gives zero color, quotients above 255 clamp to 255.
module alpha_unpremultiply_bgra_to_rgba_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [aupm_pkg::CHAN_W-1:0] req_premul_blue,
   input  logic [aupm_pkg::CHAN_W-1:0] req_premul_green,
   input  logic [aupm_pkg::CHAN_W-1:0] req_premul_red,
   input  logic [aupm_pkg::CHAN_W-1:0] req_alpha_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [aupm_pkg::CHAN_W-1:0] rsp_straight_red,
   output logic [aupm_pkg::CHAN_W-1:0] rsp_straight_green,
   output logic [aupm_pkg::CHAN_W-1:0] rsp_straight_blue,
   output logic [aupm_pkg::CHAN_W-1:0] rsp_alpha_out
);

   localparam int LAST = aupm_pkg::DIV_STEPS;

   logic                req_ready;
   logic                valid [LAST+1];
   logic                ready [LAST+2];
   aupm_pkg::stage_type data [LAST+1];
   logic [aupm_pkg::NUM_CH-1:0][aupm_pkg::CHAN_W-1:0] req_chan;
   logic [aupm_pkg::NUM_CH-1:0][aupm_pkg::CHAN_W-1:0] result;

   assign req_chan[aupm_pkg::CH_RED] = req_premul_red;
   assign req_chan[aupm_pkg::CH_GREEN] = req_premul_green;
   assign req_chan[aupm_pkg::CH_BLUE] = req_premul_blue;

   aupm_prep_cell u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .up_chan    (req_chan),
      .up_alpha   (req_alpha_in),
      .down_valid (valid[0]),
      .down_ready (ready[1]),
      .down_data  (data[0])
   );

   for (genvar k = 0; k < LAST; k++) begin : g_cell
      aupm_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (valid[k]),
         .up_ready   (ready[k+1]),
         .up_data    (data[k]),
         .down_valid (valid[k+1]),
         .down_ready (ready[k+2]),
         .down_data  (data[k+1])
      );
   end

   assign ready[0] = req_ready;
   assign ready[LAST+1] = !rsp_stall;
   assign req_stall = !ready[0];

   always_comb begin
      for (int i = 0; i < aupm_pkg::NUM_CH; i++) begin
         if (data[LAST].alpha_zero) begin
            result[i] = '0;
         end else if (data[LAST].sat[i]) begin
            result[i] = aupm_pkg::CHAN_MAX;
         end else begin
            result[i] = data[LAST].quo[i];
         end
      end
   end

   assign rsp_valid = valid[LAST];
   assign rsp_straight_red = result[aupm_pkg::CH_RED];
   assign rsp_straight_green = result[aupm_pkg::CH_GREEN];
   assign rsp_straight_blue = result[aupm_pkg::CH_BLUE];
   assign rsp_alpha_out = data[LAST].alpha;

`ifndef NO_ASSERTIONS
   a_zero_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alpha_out == '0 |->
         rsp_straight_red == '0 && rsp_straight_green == '0 && rsp_straight_blue == '0)
      else $error("zero alpha produced nonzero color");

   a_entry_free: assert property (@(posedge clock) disable iff (reset)
      !valid[0] |-> !req_stall)
      else $error("input stalled with empty entry cell");

   a_rem_red: assert property (@(posedge clock) disable iff (reset)
      valid[LAST] && !data[LAST].alpha_zero && !data[LAST].sat[aupm_pkg::CH_RED]
         |-> data[LAST].rem[aupm_pkg::CH_RED] < data[LAST].alpha)
      else $error("red remainder not below alpha");

   a_rem_green: assert property (@(posedge clock) disable iff (reset)
      valid[LAST] && !data[LAST].alpha_zero && !data[LAST].sat[aupm_pkg::CH_GREEN]
         |-> data[LAST].rem[aupm_pkg::CH_GREEN] < data[LAST].alpha)
      else $error("green remainder not below alpha");

   a_rem_blue: assert property (@(posedge clock) disable iff (reset)
      valid[LAST] && !data[LAST].alpha_zero && !data[LAST].sat[aupm_pkg::CH_BLUE]
         |-> data[LAST].rem[aupm_pkg::CH_BLUE] < data[LAST].alpha)
      else $error("blue remainder not below alpha");
`endif

endmodule
